/* sv/hes_pkg.sv */
`default_nettype none

package hes_pkg;

   localparam int WordBits   = 64;
   localparam int LenBits    = 7;
   localparam int SynBits    = 7;
   localparam int QueueDepth = 2;

   typedef enum logic {
      FUNC_ENCODE = 1'b0,
      FUNC_CHECK  = 1'b1
   } func_type;

   typedef struct packed {
      func_type              func;
      logic [WordBits-1:0]   word_in;
      logic [LenBits-1:0]    item_bits;
   } req_type;

   typedef struct packed {
      logic [WordBits-1:0]   codeword_out;
      logic [LenBits-1:0]    code_bits;
      logic [SynBits-1:0]    syndrome;
      logic                  error_found;
      logic                  bad_length;
   } rsp_type;

   // Classified item: word is the scattered data (encode) or the masked
   // codeword (check), zero when the length is rejected.
   typedef struct packed {
      func_type              func;
      logic                  bad;
      logic [WordBits-1:0]   word;
      logic [LenBits-1:0]    code_bits;
   } work_type;

   // Smallest r with 2^r >= n + r + 1.
   function automatic logic [3:0] check_bit_count(input logic [LenBits-1:0] n);
      logic [3:0] r;
      if (n == '0)               r = 4'd0;
      else if (n <= 7'd1)        r = 4'd2;
      else if (n <= 7'd4)        r = 4'd3;
      else if (n <= 7'd11)       r = 4'd4;
      else if (n <= 7'd26)       r = 4'd5;
      else if (n <= 7'd57)       r = 4'd6;
      else if (n <= 7'd120)      r = 4'd7;
      else                       r = 4'd8;
      return r;
   endfunction

   // Place data bits, lowest first, into the non-power-of-two positions.
   function automatic logic [WordBits-1:0] scatter_data(input logic [WordBits-1:0] data);
      logic [WordBits-1:0] cw;
      int j;
      cw = '0;
      j  = 0;
      for (int p = 1; p <= WordBits; p++) begin
         if ((p & (p - 1)) != 0) begin
            cw[p-1] = data[j];
            j++;
         end
      end
      return cw;
   endfunction

   // Positions whose 1-based index has bit t set.
   function automatic logic [WordBits-1:0] parity_column(input int t);
      logic [WordBits-1:0] m;
      m = '0;
      for (int p = 1; p <= WordBits; p++) begin
         if (((p >> t) & 1) == 1) begin
            m[p-1] = 1'b1;
         end
      end
      return m;
   endfunction

   // XOR of the indices of all set positions, one reduction tree per bit.
   function automatic logic [SynBits-1:0] position_syndrome(input logic [WordBits-1:0] w);
      logic [SynBits-1:0] s;
      for (int t = 0; t < SynBits; t++) begin
         s[t] = ^(w & parity_column(t));
      end
      return s;
   endfunction

endpackage

`default_nettype wire

/* sv/hamming_encode_and_syndrome.sv */
`default_nettype none

// Channel   Ports                            Payload
// request   req_valid req_ready req_payload   func, word_in, item_bits
// response  rsp_valid rsp_ready rsp_payload   codeword_out, code_bits, syndrome,
//                                             error_found, bad_length
//
// One item per cycle sustained while rsp_ready stays high. An accepted item is
// written into the queue and then loaded into the output register, from which
// it transfers as a response.
// The front classifies and scatters in the transfer cycle; the back XOR tree
// finishes the item. Synchronous reset empties the two-entry queue and the
// output register. A stalled response holds the output register; the queue
// absorbs up to two more items before req_ready falls.

module hamming_encode_and_syndrome #(
   parameter int MAX_CODE_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hes_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hes_pkg::rsp_type  rsp_payload
);
   import hes_pkg::*;

   logic     wr_valid, wr_ready;
   work_type wr_data;
   logic     pop_valid, pop_ready;
   work_type pop_data;

   hes_front #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .wr_valid    (wr_valid),
      .wr_ready    (wr_ready),
      .wr_data     (wr_data)
   );

   hes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (wr_valid),
      .push_ready (wr_ready),
      .push_data  (wr_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   hes_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* sv/hes_front.sv */
`default_nettype none

module hes_front #(
   parameter int MAX_CODE_BITS = 64
) (
   input  logic              req_valid,
   output logic              req_ready,
   input  hes_pkg::req_type  req_payload,
   output logic              wr_valid,
   input  logic              wr_ready,
   output hes_pkg::work_type wr_data
);
   import hes_pkg::*;

   localparam logic [LenBits:0] MaxBits = (LenBits + 1)'(MAX_CODE_BITS);

   logic [3:0]          r;
   logic [LenBits:0]    total;
   logic                bad;
   logic [WordBits-1:0] mask;
   logic [WordBits-1:0] masked;

   always_comb begin
      r     = check_bit_count(req_payload.item_bits);
      total = {1'b0, req_payload.item_bits} + {(LenBits - 3)'(0), r};
      for (int i = 0; i < WordBits; i++) begin
         mask[i] = LenBits'(i) < req_payload.item_bits;
      end
      masked = req_payload.word_in & mask;
      if (req_payload.func == FUNC_ENCODE) begin
         bad = total > MaxBits;
      end else begin
         bad = {1'b0, req_payload.item_bits} > MaxBits;
      end
   end

   always_comb begin
      wr_data.func      = req_payload.func;
      wr_data.bad       = bad;
      wr_data.word      = '0;
      wr_data.code_bits = '0;
      if (!bad) begin
         if (req_payload.func == FUNC_ENCODE) begin
            wr_data.word      = scatter_data(masked);
            wr_data.code_bits = total[LenBits-1:0];
         end else begin
            wr_data.word = masked;
         end
      end
   end

   assign wr_valid  = req_valid;
   assign req_ready = wr_ready;

endmodule

`default_nettype wire

/* sv/hes_queue.sv */
`default_nettype none

module hes_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  hes_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output hes_pkg::work_type pop_data
);
   import hes_pkg::*;

   localparam int PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntBits = $clog2(QueueDepth + 1);

   work_type            mem_ff [QueueDepth];
   logic [PtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic                push;
   logic                pop;

   assign push_ready = count_ff < CntBits'(QueueDepth);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] p);
      logic [PtrBits-1:0] n;
      if (p == PtrBits'(QueueDepth - 1)) n = '0;
      else                               n = p + 1'b1;
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(QueueDepth))
      else $error("queue count past depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count missed a pop");

endmodule

`default_nettype wire

/* sv/hes_back.sv */
`default_nettype none

module hes_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  hes_pkg::work_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hes_pkg::rsp_type  rsp_payload
);
   import hes_pkg::*;

   logic               valid_ff, valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [SynBits-1:0] syn;
   logic               pop;

   assign pop_ready = !valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      syn    = position_syndrome(pop_data.word);
      rsp_in = '0;
      rsp_in.bad_length = pop_data.bad;
      if (pop_data.func == FUNC_ENCODE) begin
         rsp_in.codeword_out = pop_data.word;
         // drop the syndrome bits into the power-of-two positions
         for (int t = 0; t < SynBits; t++) begin
            rsp_in.codeword_out[(1 << t) - 1] = syn[t];
         end
         rsp_in.code_bits = pop_data.code_bits;
      end else begin
         rsp_in.syndrome    = syn;
         rsp_in.error_found = syn != '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop)                      valid_in = 1'b1;
      else if (valid_ff && rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

   a_bad_clears: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ff.bad_length |->
         rsp_ff.codeword_out == '0 && rsp_ff.code_bits == '0 &&
         rsp_ff.syndrome == '0 && !rsp_ff.error_found)
      else $error("rejected length left a nonzero field");

   a_encode_no_syn: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ff.code_bits != '0 |->
         rsp_ff.syndrome == '0 && !rsp_ff.error_found)
      else $error("encode result carries a syndrome");

   a_error_flag: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> rsp_ff.error_found == (rsp_ff.syndrome != '0))
      else $error("error flag disagrees with syndrome");

endmodule

`default_nettype wire
